// ===== design/btlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared constants for the binary trie longest-prefix-match block.
// ----------------------------------------------------------------------------
package btlpm_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int HOP_BITS_DEF   = 16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

// ===== design/btlpm_ram.sv =====
// ----------------------------------------------------------------------------
// btlpm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/binary_trie_longest_prefix_match.sv =====
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Unibit binary trie for longest-prefix match with insert and lookup.
// ----------------------------------------------------------------------------
//  channel | signals                                 | dir
//  in      | in_valid in_stall opcode address         | beat in
//          | prefix_len hop_in                        |
//  out     | out_valid out_stall hop_out found status | beat out
//
//  One item at a time; the node memory walk is one read per trie level.
//  Lookup walks the matched path, then finishes. Insert walks it, checks
//  the pool, then adds new nodes and sets the leaf (ends if full). Root node
//  lives in flops, cleared by rst_n; other nodes are cleared as they are
//  allocated, so no clearing pass is needed.
//  A result waits in the output register while the next beat is taken;
//  completion holds only if that register is still occupied and stalled.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match
    import btlpm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int HOP_BITS   = HOP_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [ADDR_BITS-1:0]             address,
    input  logic [$clog2(ADDR_BITS+1)-1:0]   prefix_len,
    input  logic [HOP_BITS-1:0]              hop_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [HOP_BITS-1:0]              hop_out,
    output logic                             found,
    output logic                             status
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam int LEN_W = $clog2(ADDR_BITS + 1);
    localparam int CMP_W = CNT_W + LEN_W;
    // entry: {left, right, valid, hop}
    localparam int ENT_W = 2 * IDX_W + 1 + HOP_BITS;
    localparam int VLD_B = HOP_BITS;
    localparam int RGT_L = HOP_BITS + 1;
    localparam int LFT_L = HOP_BITS + 1 + IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [ENT_W-1:0]     root_reg, root_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 op_reg, op_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     level_reg, level_next;
    logic [HOP_BITS-1:0]  hop_reg, hop_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [ENT_W-1:0]     ent_reg, ent_next;
    logic                 hit_reg, hit_next;
    logic [HOP_BITS-1:0]  best_reg, best_next;
    logic                 res_st_reg, res_st_next;
    logic [HOP_BITS-1:0]  hop_out_reg, hop_out_next;
    logic                 found_reg, found_next;
    logic                 status_reg, status_next;

    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [ENT_W-1:0]     ram_wdata, ram_rdata;

    logic [ENT_W-1:0]     ent;
    logic                 bit_now;
    logic [IDX_W-1:0]     nxt;
    logic                 go_on;
    logic                 walk_hit;
    logic [HOP_BITS-1:0]  walk_best;
    logic [CMP_W-1:0]     needed, room;
    logic                 pool_full;
    logic [ENT_W-1:0]     upd_ent;
    logic                 out_free;

    btlpm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        // current node: root flops on the first level, memory data after
        ent       = (state_reg == S_WALK) ? ram_rdata : root_reg;
        bit_now   = addr_reg[ADDR_BITS-1];
        nxt       = bit_now ? ent[RGT_L +: IDX_W] : ent[LFT_L +: IDX_W];
        go_on     = (level_reg < len_reg) && (nxt != '0);
        walk_hit  = hit_reg;
        walk_best = best_reg;
        if (state_reg == S_WALK && ent[VLD_B])
        begin
            walk_hit  = 1'b1;
            walk_best = ent[HOP_BITS-1:0];
        end

        needed    = CMP_W'(len_reg) - CMP_W'(level_reg);
        room      = CMP_W'(CNT_W'(NODE_COUNT) - used_reg);
        pool_full = (used_reg > CNT_W'(NODE_COUNT)) || (needed > room);

        // parent with the new child hooked on the current address bit
        upd_ent = ent_reg;
        if (bit_now)
        begin
            upd_ent[RGT_L +: IDX_W] = used_reg[IDX_W-1:0];
        end
        else
        begin
            upd_ent[LFT_L +: IDX_W] = used_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        level_next     = level_reg;
        hop_next       = hop_reg;
        cur_next       = cur_reg;
        ent_next       = ent_reg;
        hit_next       = hit_reg;
        best_next      = best_reg;
        res_st_next    = res_st_reg;
        hop_out_next   = hop_out_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = ent_reg;
        ram_re         = 1'b0;
        ram_raddr      = nxt;
        in_stall       = (state_reg != S_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    addr_next  = address;
                    hop_next   = hop_in;
                    level_next = '0;
                    cur_next   = '0;
                    if (opcode == OP_LOOKUP || prefix_len > LEN_W'(ADDR_BITS))
                    begin
                        len_next = LEN_W'(ADDR_BITS);
                    end
                    else
                    begin
                        len_next = prefix_len;
                    end
                    state_next = S_START;
                end
            end
            S_START, S_WALK:
            begin
                if (state_reg == S_START)
                begin
                    hit_next  = root_reg[VLD_B];
                    best_next = root_reg[HOP_BITS-1:0];
                end
                else
                begin
                    hit_next  = walk_hit;
                    best_next = walk_best;
                end
                if (go_on)
                begin
                    ram_re     = 1'b1;
                    cur_next   = nxt;
                    level_next = level_reg + 1'b1;
                    addr_next  = addr_reg << 1;
                    state_next = S_WALK;
                end
                else if (op_reg == OP_INSERT)
                begin
                    ent_next   = ent;
                    state_next = S_CHECK;
                end
                else
                begin
                    res_st_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_CHECK:
            begin
                hit_next  = 1'b0;
                best_next = '0;
                if (pool_full)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (level_reg < len_reg)
                begin
                    if (cur_reg == '0)
                    begin
                        root_next = upd_ent;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = upd_ent;
                    end
                    cur_next   = used_reg[IDX_W-1:0];
                    ent_next   = '0;
                    used_next  = used_reg + 1'b1;
                    level_next = level_reg + 1'b1;
                    addr_next  = addr_reg << 1;
                end
                else
                begin
                    ent_next = ent_reg;
                    ent_next[VLD_B] = 1'b1;
                    ent_next[HOP_BITS-1:0] = hop_reg;
                    if (cur_reg == '0)
                    begin
                        root_next = ent_next;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ent_next;
                    end
                    res_st_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hop_out_next   = hit_reg ? best_reg : '0;
                    found_next     = hit_reg;
                    status_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= CNT_W'(1);
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        len_reg     <= len_next;
        level_reg   <= level_next;
        hop_reg     <= hop_next;
        cur_reg     <= cur_next;
        ent_reg     <= ent_next;
        hit_reg     <= hit_next;
        best_reg    <= best_next;
        res_st_reg  <= res_st_next;
        hop_out_reg <= hop_out_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign hop_out   = hop_out_reg;
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

// ===== verif/btlpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlpm_checker
// Watches both channels of the trie block, keeps its own copy of the node
// memory, works out the answer to every accepted request beat and compares
// each result beat with the oldest answer still due.
// ----------------------------------------------------------------------------
module btlpm_checker
    import btlpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      opcode,
    input  logic [ADDR_BITS_DEF-1:0]  address,
    input  logic [5:0]                prefix_len,
    input  logic [HOP_BITS_DEF-1:0]   hop_in,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [HOP_BITS_DEF-1:0]   hop_out,
    input  logic                      found,
    input  logic                      status,
    output int                        fail_count,
    output int                        pending
);

    localparam int NODES = NODE_COUNT_DEF;
    localparam int AW    = ADDR_BITS_DEF;
    localparam int HW    = HOP_BITS_DEF;
    localparam int IW    = $clog2(NODES);

    typedef struct packed {
        logic [HW-1:0] hop;
        logic          hit;
        logic          outcome;
    } lpm_answer_t;

    logic [IW-1:0] left_kid  [NODES];
    logic [IW-1:0] right_kid [NODES];
    logic          leaf_set  [NODES];
    logic [HW-1:0] leaf_hop  [NODES];
    int            nodes_used;

    lpm_answer_t   answers_due [$];

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t ns: %s expected %h got %h", $time, what, want, got);
        fail_count++;
    endtask

    // Walks the trie copy; inserts update it, lookups only read it.
    function automatic lpm_answer_t trie_answer(input logic op, input logic [AW-1:0] a,
                                                input logic [5:0] plen,
                                                input logic [HW-1:0] h);
        lpm_answer_t ans;
        int len;
        int cur;
        int lvl;
        int nxt;
        int fresh;
        ans = '0;
        cur = 0;
        lvl = 0;
        if (op == OP_INSERT)
        begin
            len = (plen > AW) ? AW : int'(plen);
            while (lvl < len)
            begin
                nxt = int'(a[AW-1-lvl] ? right_kid[cur] : left_kid[cur]);
                if (nxt == 0)
                    break;
                cur = nxt;
                lvl++;
            end
            // rejected whole when the pool cannot hold the missing path
            if (len - lvl > NODES - nodes_used)
                ans.outcome = ST_FULL;
            else
            begin
                while (lvl < len)
                begin
                    fresh = nodes_used;
                    nodes_used++;
                    left_kid[fresh]  = '0;
                    right_kid[fresh] = '0;
                    leaf_set[fresh]  = 1'b0;
                    leaf_hop[fresh]  = '0;
                    if (a[AW-1-lvl])
                        right_kid[cur] = fresh[IW-1:0];
                    else
                        left_kid[cur] = fresh[IW-1:0];
                    cur = fresh;
                    lvl++;
                end
                leaf_set[cur] = 1'b1;
                leaf_hop[cur] = h;
                ans.outcome = ST_OK;
            end
        end
        else
        begin
            if (leaf_set[0])
            begin
                ans.hit = 1'b1;
                ans.hop = leaf_hop[0];
            end
            for (lvl = 0; lvl < AW; lvl++)
            begin
                nxt = int'(a[AW-1-lvl] ? right_kid[cur] : left_kid[cur]);
                if (nxt == 0)
                    break;
                cur = nxt;
                if (leaf_set[cur])
                begin
                    ans.hit = 1'b1;
                    ans.hop = leaf_hop[cur];
                end
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lpm_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                left_kid[i]  = '0;
                right_kid[i] = '0;
                leaf_set[i]  = 1'b0;
                leaf_hop[i]  = '0;
            end
            nodes_used = 1;
            answers_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                answers_due.push_back(trie_answer(opcode, address, prefix_len, hop_in));
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                    flag_mismatch("result beat with nothing due", 32'h0,
                                  32'({hop_out, found, status}));
                else
                begin
                    want = answers_due.pop_front();
                    if (hop_out !== want.hop)
                        flag_mismatch("hop_out", 32'(want.hop), 32'(hop_out));
                    if (found !== want.hit)
                        flag_mismatch("found", 32'(want.hit), 32'(found));
                    if (status !== want.outcome)
                        flag_mismatch("status", 32'(want.outcome), 32'(status));
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== verif/binary_trie_longest_prefix_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_tb
// Drives route inserts and address lookups into the trie block with random
// gaps and result stalls, including one long result hold-off that backs up
// the input. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_tb
    import btlpm_pkg::*;
();

    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT      = 400;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int TAIL_CYCLES  = 60;
    localparam int STORE_MAX    = 512;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] hop_in;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] hop_out;
    logic        found;
    logic        status;
    int          fail_count;
    int          pending;

    int          beats_sent;
    int          cycles;
    bit          calm;
    bit          held_off;

    logic [31:0] known_base [$];
    int          known_len  [$];

    binary_trie_longest_prefix_match DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .address    (address),
        .prefix_len (prefix_len),
        .hop_in     (hop_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hop_out    (hop_out),
        .found      (found),
        .status     (status)
    );

    btlpm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .address    (address),
        .prefix_len (prefix_len),
        .hop_in     (hop_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hop_out    (hop_out),
        .found      (found),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: short random stalls, plus one long hold-off that fills the block.
    initial
    begin : receiver
        out_stall = 1'b0;
        held_off = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && beats_sent >= HOLD_AT)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic op, input logic [31:0] a, input logic [5:0] len,
                             input logic [15:0] h);
        in_valid   <= 1'b1;
        opcode     <= op;
        address    <= a;
        prefix_len <= len;
        hop_in     <= h;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        beats_sent++;
        if (op == OP_INSERT)
        begin
            if (known_base.size() < STORE_MAX)
            begin
                known_base.push_back(a);
                known_len.push_back((len > 32) ? 32 : int'(len));
            end
            else
            begin
                int slot;
                slot = $urandom_range(0, STORE_MAX - 1);
                known_base[slot] = a;
                known_len[slot] = (len > 32) ? 32 : int'(len);
            end
        end
    endtask

    function automatic logic [31:0] keep_mask(input int len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    task automatic random_item();
        int          pick;
        int          slot;
        int          len;
        logic [31:0] base;
        logic [31:0] mask;
        logic [31:0] a;
        logic [5:0]  plen;
        pick = $urandom_range(0, 99);
        base = $urandom;
        len = 32;
        if (known_base.size() > 0)
        begin
            slot = $urandom_range(0, known_base.size() - 1);
            base = known_base[slot];
            len = known_len[slot];
        end
        mask = keep_mask(len);
        if ($urandom_range(0, 99) < 45)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                plen = 6'($urandom_range(0, 8));
            else if (pick < 65)
                plen = 6'($urandom_range(9, 31));
            else if (pick < 88)
                plen = 6'd32;
            else
                plen = 6'($urandom_range(33, 63));
            // extend a stored route 40% of the time so paths share nodes
            if (known_base.size() > 0 && $urandom_range(0, 99) < 40)
                a = (base & mask) | ($urandom & ~mask);
            else
                a = $urandom;
            send_beat(OP_INSERT, a, plen, 16'($urandom));
        end
        else
        begin
            if (known_base.size() > 0 && pick < 55)
                a = (base & mask) | ($urandom & ~mask);
            else if (known_base.size() > 0 && pick < 70)
                a = (len > 0) ? base ^ (32'h1 << (32 - len)) : base;
            else if (pick < 75)
                a = 32'h0;
            else if (pick < 80)
                a = 32'hFFFF_FFFF;
            else
                a = $urandom;
            send_beat(OP_LOOKUP, a, 6'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_LOOKUP;
        address = '0;
        prefix_len = '0;
        hop_in = '0;
        beats_sent = 0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty trie, default route, extremes, overwrite, overlong prefixes
        send_beat(OP_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        send_beat(OP_INSERT, 32'h1357_9BDF, 6'd0, 16'hFFFF);
        send_beat(OP_LOOKUP, 32'h2468_ACE0, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'h8000_0000, 6'd1, 16'h0001);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h8000);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'h0000);
        send_beat(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'h0000_0000, 6'd32, 16'h0000);
        send_beat(OP_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'hC0A8_0000, 6'd16, 16'h1234);
        send_beat(OP_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h4321);
        send_beat(OP_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'h5A5A_5A5A, 6'd63, 16'hAAAA);
        send_beat(OP_LOOKUP, 32'h5A5A_5A5A, 6'd0, 16'h0000);
        send_beat(OP_LOOKUP, 32'h5A5A_5A5B, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'hA5A5_A5A5, 6'd40, 16'h5555);
        send_beat(OP_LOOKUP, 32'hA5A5_A5A5, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'hDEAD_BEEF, 6'd33, 16'h00FF);
        send_beat(OP_LOOKUP, 32'hDEAD_BEEF, 6'd0, 16'h0000);
        send_beat(OP_INSERT, 32'h0000_0000, 6'd0, 16'h7777);
        send_beat(OP_LOOKUP, 32'h1234_5678, 6'd0, 16'h0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            random_item();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/btlpm_pkg.sv
design/btlpm_ram.sv
design/binary_trie_longest_prefix_match.sv
verif/btlpm_checker.sv
verif/binary_trie_longest_prefix_match_tb.sv
